@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker of the level tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ALP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ALP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/alp_pkg.sv @@
// Shared constants, types and sequencer states of the audio level peak tracker.
package alp_pkg;

    // Filter spans and baseline length
    localparam int AVG_SPAN   = 16;
    localparam int PEAK_SPAN  = 8;
    localparam int BASE_COUNT = 16;

    // Field and state widths
    localparam int LVL_W  = 10;
    localparam int FRAC_W = 16;
    localparam int EMA_W  = LVL_W + FRAC_W;
    localparam int SUM_W  = 18;
    localparam int CNT_W  = 8;
    localparam int PCT_W  = 8;

    // Shared divider: two quotient bits per cycle
    localparam int DIV_W      = 28;
    localparam int DIVR_W     = 10;
    localparam int DIV_STEPS  = DIV_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Mapping constants
    localparam int PCT_SCALE   = 100;
    localparam int INFLATE_TOP = 1024;
    localparam int PROD_W      = 17;

    // Configuration register indexes and reset values
    localparam logic CFG_ALL_BANDS = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;
    localparam logic [LVL_W-1:0] THRESHOLD_RESET = LVL_W'(50);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE,
        S_BASE_DIV,
        S_BASE_WAIT,
        S_LISTEN,
        S_PEAK_DIV,
        S_PEAK_WAIT,
        S_AVG_DIV,
        S_AVG_WAIT,
        S_HIST,
        S_PCT_DIV,
        S_PCT_WAIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic             valid;
        logic [PCT_W-1:0] percent;
        logic             span_invalid;
        logic             baseline_done;
    } t_result;

endpackage

@@ rtl/alp_div.sv @@
// Shared restoring divider, two quotient bits per cycle.
module alp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  alp_pkg::t_div_req i_req,
    output alp_pkg::t_div_rsp o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [alp_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [alp_pkg::DIV_W-1:0]       r_quo;
    logic [alp_pkg::DIVR_W-1:0]      r_rem;
    logic [alp_pkg::DIVR_W-1:0]      r_div;
    logic [alp_pkg::DIV_W-1:0]       n_quo;
    logic [alp_pkg::DIVR_W-1:0]      n_rem;
    logic                            last_step;

    assign last_step = (r_cnt == alp_pkg::DIV_CNT_W'(alp_pkg::DIV_STEPS - 1));

    // Two compare-subtract steps on the partial remainder
    always_comb begin
        logic [alp_pkg::DIVR_W:0] trial;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_quo[alp_pkg::DIV_W-1]};
            n_quo = {n_quo[alp_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem    = alp_pkg::DIVR_W'(trial - {1'b0, r_div});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = trial[alp_pkg::DIVR_W-1:0];
            end
        end
    end

    // Control: load on start, count steps, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ rtl/alp_ctrl.sv @@
// Sequencer and tracking state: baseline, averages, history and percent mapping.
module alp_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_operation,
    input  logic [alp_pkg::LVL_W-1:0]  i_level,
    input  logic [alp_pkg::LVL_W-1:0]  i_threshold,
    input  logic                       i_out_free,
    output logic                       o_in_ready,
    output alp_pkg::t_div_req          o_div_req,
    input  alp_pkg::t_div_rsp          i_div_rsp,
    output alp_pkg::t_result           o_result
);

    alp_pkg::t_state                r_state;
    alp_pkg::t_state                n_state;

    logic [alp_pkg::LVL_W-1:0]      r_level;
    logic [alp_pkg::EMA_W-1:0]      r_level_average;
    logic [alp_pkg::EMA_W-1:0]      r_peak_average;
    logic [alp_pkg::LVL_W-1:0]      r_prev;
    logic [alp_pkg::LVL_W-1:0]      r_prev2;
    logic                           r_toggle;
    logic [alp_pkg::SUM_W-1:0]      r_base_sum;
    logic [alp_pkg::LVL_W-1:0]      r_base_max;
    logic [alp_pkg::CNT_W-1:0]      r_base_count;
    logic [alp_pkg::PCT_W-1:0]      r_pct;
    logic                           r_inv;
    logic                           r_done;

    logic [alp_pkg::SUM_W-1:0]      base_sum_new;
    logic [alp_pkg::LVL_W-1:0]      base_max_new;
    logic [alp_pkg::CNT_W-1:0]      base_count_new;
    logic                           base_complete;
    logic [alp_pkg::LVL_W:0]        inflate_gap;
    logic [alp_pkg::LVL_W-1:0]      inflated;
    logic                           local_max;
    logic [alp_pkg::LVL_W-1:0]      lvl_thr;
    logic [alp_pkg::LVL_W-1:0]      avg_int;
    logic [alp_pkg::LVL_W-1:0]      peak_int;
    logic                           span_ok;
    logic [alp_pkg::PROD_W-1:0]     pct_prod;
    logic [alp_pkg::PCT_W-1:0]      pct_sat;

    // Dividend of one filter step: twice the distance to the target
    function automatic logic [alp_pkg::DIV_W-1:0] ema_dividend(
        logic [alp_pkg::EMA_W-1:0] e,
        logic [alp_pkg::LVL_W-1:0] tgt
    );
        logic [alp_pkg::EMA_W-1:0] t;
        logic [alp_pkg::EMA_W-1:0] diff;
        t    = {tgt, alp_pkg::FRAC_W'(0)};
        diff = (t >= e) ? (t - e) : (e - t);
        return alp_pkg::DIV_W'({diff, 1'b0});
    endfunction

    // Move the average by the quotient toward the target
    function automatic logic [alp_pkg::EMA_W-1:0] ema_update(
        logic [alp_pkg::EMA_W-1:0] e,
        logic [alp_pkg::LVL_W-1:0] tgt,
        logic [alp_pkg::DIV_W-1:0] q
    );
        logic [alp_pkg::EMA_W-1:0] t;
        logic [alp_pkg::EMA_W-1:0] mag;
        t   = {tgt, alp_pkg::FRAC_W'(0)};
        mag = q[alp_pkg::EMA_W-1:0];
        return (t >= e) ? (e + mag) : (e - mag);
    endfunction

    // Baseline accumulation
    assign base_sum_new   = r_base_sum + alp_pkg::SUM_W'(r_level);
    assign base_max_new   = (r_level > r_base_max) ? r_level : r_base_max;
    assign base_count_new = r_base_count + alp_pkg::CNT_W'(1);
    assign base_complete  = (base_count_new >= alp_pkg::CNT_W'(alp_pkg::BASE_COUNT));

    // Peak target and local maximum detection
    assign inflate_gap = (alp_pkg::LVL_W+1)'(alp_pkg::INFLATE_TOP) - {1'b0, r_level};
    assign inflated    = alp_pkg::LVL_W'((inflate_gap >> 2) + {1'b0, r_level});
    assign local_max   = (r_level < r_prev) && (r_prev > r_prev2) &&
                         ({r_level, alp_pkg::FRAC_W'(0)} > r_level_average);

    // Percent mapping between the integer parts
    assign lvl_thr  = (r_level < i_threshold) ? '0 : r_level;
    assign avg_int  = r_level_average[alp_pkg::EMA_W-1:alp_pkg::FRAC_W];
    assign peak_int = r_peak_average[alp_pkg::EMA_W-1:alp_pkg::FRAC_W];
    assign span_ok  = (peak_int > avg_int);
    assign pct_prod = alp_pkg::PROD_W'(lvl_thr - avg_int) *
                      alp_pkg::PROD_W'(alp_pkg::PCT_SCALE);
    assign pct_sat  = (|i_div_rsp.quotient[alp_pkg::DIV_W-1:alp_pkg::PCT_W]) ?
                      '1 : i_div_rsp.quotient[alp_pkg::PCT_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            alp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_operation ? alp_pkg::S_BASE : alp_pkg::S_LISTEN;
                end
            end
            alp_pkg::S_BASE: begin
                n_state = base_complete ? alp_pkg::S_BASE_DIV : alp_pkg::S_FIN;
            end
            alp_pkg::S_BASE_DIV: n_state = alp_pkg::S_BASE_WAIT;
            alp_pkg::S_BASE_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = alp_pkg::S_FIN;
                end
            end
            alp_pkg::S_LISTEN: begin
                if (local_max) begin
                    n_state = alp_pkg::S_PEAK_DIV;
                end else begin
                    n_state = r_toggle ? alp_pkg::S_AVG_DIV : alp_pkg::S_HIST;
                end
            end
            alp_pkg::S_PEAK_DIV: n_state = alp_pkg::S_PEAK_WAIT;
            alp_pkg::S_PEAK_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = r_toggle ? alp_pkg::S_AVG_DIV : alp_pkg::S_HIST;
                end
            end
            alp_pkg::S_AVG_DIV: n_state = alp_pkg::S_AVG_WAIT;
            alp_pkg::S_AVG_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = alp_pkg::S_HIST;
                end
            end
            alp_pkg::S_HIST: begin
                n_state = (span_ok && (lvl_thr > avg_int)) ? alp_pkg::S_PCT_DIV
                                                          : alp_pkg::S_FIN;
            end
            alp_pkg::S_PCT_DIV: n_state = alp_pkg::S_PCT_WAIT;
            alp_pkg::S_PCT_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = alp_pkg::S_FIN;
                end
            end
            alp_pkg::S_FIN: begin
                if (i_out_free) begin
                    n_state = alp_pkg::S_IDLE;
                end
            end
            default: n_state = alp_pkg::S_IDLE;
        endcase
    end

    // Outputs: handshake, divider request, result
    always_comb begin
        o_in_ready         = (r_state == alp_pkg::S_IDLE);
        o_div_req.start    = 1'b0;
        o_div_req.dividend = '0;
        o_div_req.divisor  = '0;
        unique case (r_state)
            alp_pkg::S_BASE_DIV: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = alp_pkg::DIV_W'(r_base_sum);
                o_div_req.divisor  = alp_pkg::DIVR_W'(alp_pkg::BASE_COUNT);
            end
            alp_pkg::S_PEAK_DIV: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = ema_dividend(r_peak_average, inflated);
                o_div_req.divisor  = alp_pkg::DIVR_W'(alp_pkg::PEAK_SPAN + 1);
            end
            alp_pkg::S_AVG_DIV: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = ema_dividend(r_level_average, r_level);
                o_div_req.divisor  = alp_pkg::DIVR_W'(alp_pkg::AVG_SPAN + 1);
            end
            alp_pkg::S_PCT_DIV: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = alp_pkg::DIV_W'(pct_prod);
                o_div_req.divisor  = peak_int - avg_int;
            end
            default: begin
                o_div_req.start = 1'b0;
            end
        endcase
        o_result.valid         = (r_state == alp_pkg::S_FIN) && i_out_free;
        o_result.percent       = r_pct;
        o_result.span_invalid  = r_inv;
        o_result.baseline_done = r_done;
    end

    // Tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= alp_pkg::S_IDLE;
            r_level_average <= '0;
            r_peak_average  <= '0;
            r_prev          <= '0;
            r_prev2         <= '0;
            r_toggle        <= 1'b1;
            r_base_sum      <= '0;
            r_base_max      <= '0;
            r_base_count    <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                alp_pkg::S_BASE: begin
                    r_base_sum   <= base_sum_new;
                    r_base_max   <= base_max_new;
                    r_base_count <= base_count_new;
                end
                alp_pkg::S_BASE_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_level_average <= {i_div_rsp.quotient[alp_pkg::LVL_W-1:0],
                                            alp_pkg::FRAC_W'(0)};
                        r_peak_average  <= {r_base_max, alp_pkg::FRAC_W'(0)};
                        r_base_sum      <= '0;
                        r_base_max      <= '0;
                        r_base_count    <= '0;
                    end
                end
                alp_pkg::S_PEAK_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_peak_average <= ema_update(r_peak_average, inflated,
                                                     i_div_rsp.quotient);
                    end
                end
                alp_pkg::S_AVG_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_level_average <= ema_update(r_level_average, r_level,
                                                      i_div_rsp.quotient);
                    end
                end
                alp_pkg::S_HIST: begin
                    r_toggle <= ~r_toggle;
                    r_prev2  <= r_prev;
                    r_prev   <= r_level;
                end
                default: begin
                    r_toggle <= r_toggle;
                end
            endcase
        end
    end

    // Captured level and result fields
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            alp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    r_level <= i_level;
                end
            end
            alp_pkg::S_BASE: begin
                r_pct  <= '0;
                r_inv  <= 1'b0;
                r_done <= 1'b0;
            end
            alp_pkg::S_BASE_WAIT: begin
                if (i_div_rsp.done) begin
                    r_done <= 1'b1;
                end
            end
            alp_pkg::S_HIST: begin
                r_pct  <= '0;
                r_inv  <= ~span_ok;
                r_done <= 1'b0;
            end
            alp_pkg::S_PCT_WAIT: begin
                if (i_div_rsp.done) begin
                    r_pct <= pct_sat;
                end
            end
            default: begin
                r_pct <= r_pct;
            end
        endcase
    end

endmodule

@@ rtl/audio_level_peak_tracker.sv @@
// Top level of the audio level peak tracker: ports, configuration, level select, result register.
//
//  channel  | signals                                        | transfer when
//  ---------+------------------------------------------------+--------------------------
//  input    | i_in_valid, o_in_ready, i_operation, i_band_*  | i_in_valid & o_in_ready
//  output   | o_out_valid, i_out_ready, o_brightness_percent,| o_out_valid & i_out_ready
//           | o_span_invalid, o_baseline_done                |
//  config   | i_cfg_we, i_cfg_index, i_cfg_data              | i_cfg_we
//
// One item at a time. A baseline item passes through the shared divider once when it
// completes the baseline; a listen item makes up to three passes through the shared
// divider (peak filter, average filter, percent).
// Reset is synchronous, active low, and restores the register defaults.
// A held result does not block the next item; the sequencer waits only when a
// new result is ready and the output register is still full.
module audio_level_peak_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [alp_pkg::LVL_W-1:0]         i_band_0,
    input  logic [alp_pkg::LVL_W-1:0]         i_band_1,
    input  logic [alp_pkg::LVL_W-1:0]         i_band_2,
    input  logic [alp_pkg::LVL_W-1:0]         i_band_3,
    input  logic [alp_pkg::LVL_W-1:0]         i_band_4,
    input  logic [alp_pkg::LVL_W-1:0]         i_band_5,
    input  logic [alp_pkg::LVL_W-1:0]         i_band_6,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [alp_pkg::PCT_W-1:0]         o_brightness_percent,
    output logic                              o_span_invalid,
    output logic                              o_baseline_done,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [alp_pkg::LVL_W-1:0]         i_cfg_data
);

    logic                          r_all_bands;
    logic [alp_pkg::LVL_W-1:0]     r_level_threshold;
    logic                          r_out_valid;
    logic [alp_pkg::PCT_W-1:0]     r_pct;
    logic                          r_inv;
    logic                          r_done;

    logic [alp_pkg::LVL_W-1:0]     level;
    logic                          out_free;
    alp_pkg::t_div_req             div_req;
    alp_pkg::t_div_rsp             div_rsp;
    alp_pkg::t_result              result;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_all_bands       <= 1'b0;
            r_level_threshold <= alp_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                alp_pkg::CFG_ALL_BANDS: r_all_bands       <= i_cfg_data[0];
                alp_pkg::CFG_THRESHOLD: r_level_threshold <= i_cfg_data;
                default:                r_all_bands       <= r_all_bands;
            endcase
        end
    end

    // Level: band 0, or the largest band
    always_comb begin
        logic [alp_pkg::LVL_W-1:0] bands [6];
        bands[0] = i_band_1;
        bands[1] = i_band_2;
        bands[2] = i_band_3;
        bands[3] = i_band_4;
        bands[4] = i_band_5;
        bands[5] = i_band_6;
        level    = i_band_0;
        if (r_all_bands) begin
            for (int k = 0; k < 6; k++) begin
                if (bands[k] > level) begin
                    level = bands[k];
                end
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    alp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_level     (level),
        .i_threshold (r_level_threshold),
        .i_out_free  (out_free),
        .o_in_ready  (o_in_ready),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_result    (result)
    );

    alp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Output register: hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_pct  <= result.percent;
            r_inv  <= result.span_invalid;
            r_done <= result.baseline_done;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_brightness_percent = r_pct;
    assign o_span_invalid       = r_inv;
    assign o_baseline_done      = r_done;

endmodule

@@ rtl/alp_checker.sv @@
// Port-level checker of the audio level peak tracker and its bind.
`include "assert_macros.svh"

module alp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic [alp_pkg::PCT_W-1:0]         o_brightness_percent,
    input  logic                              o_span_invalid,
    input  logic                              o_baseline_done
);

    // Hold a stalled result
    `ALP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_brightness_percent), "stalled result dropped or changed")

    // Drop ready after a transfer in: one item at a time
    `ALP_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second item taken while busy")

    // Empty span maps to zero
    `ALP_ASSERT_IMPLY(a_invalid_zero, i_clk, i_rst_n, o_out_valid && o_span_invalid, o_brightness_percent == '0, "nonzero percent on empty span")

    // Baseline completion carries no percent and no span flag
    `ALP_ASSERT_IMPLY(a_done_clean, i_clk, i_rst_n, o_out_valid && o_baseline_done, (o_brightness_percent == '0) && !o_span_invalid, "baseline result carries mapping data")

endmodule

bind audio_level_peak_tracker alp_checker u_alp_checker (.*);
